### rtl/tilt_angle_kalman_fusion_assert.svh
// Assertion macros for the tilt fusion block.
`ifndef TILT_ANGLE_KALMAN_FUSION_ASSERT_SVH
`define TILT_ANGLE_KALMAN_FUSION_ASSERT_SVH
`ifndef SYNTHESIS
`define TAK_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tak assertion failed");
`define TAK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tak assertion failed");
`else
`define TAK_ASSERT(lbl, clk, rst, ante, cons)
`define TAK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/tak_pkg.sv
package tak_pkg;

   localparam logic signed [31:0] Q_ONE       = 32'sd65536;
   localparam logic signed [32:0] ANGLE_LIMIT = 33'sd11796480;
   localparam logic signed [32:0] RATE_LIMIT  = 33'sd131072000;

   localparam logic [23:0] ANGLE_NOISE_RST   = 24'd16777;
   localparam logic [23:0] BIAS_NOISE_RST    = 24'd50332;
   localparam logic [23:0] MEASURE_NOISE_RST = 24'd8388608;
   localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd83886;

   localparam logic [7:0] CSR_ANGLE_NOISE   = 8'd0;
   localparam logic [7:0] CSR_BIAS_NOISE    = 8'd1;
   localparam logic [7:0] CSR_MEASURE_NOISE = 8'd2;
   localparam logic [7:0] CSR_SAMPLE_PERIOD = 8'd3;

   typedef struct packed {
      logic [23:0] angle_noise;
      logic [23:0] bias_noise;
      logic [23:0] measure_noise;
      logic [23:0] sample_period;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] ang;
      logic signed [31:0] bia;
      logic signed [31:0] p00;
      logic signed [31:0] p01;
      logic signed [31:0] p10;
      logic signed [31:0] p11;
   } state_type;

   localparam state_type STATE_RESET = '{ang: 32'sd0, bia: 32'sd0, p00: Q_ONE,
                                         p01: 32'sd0, p10: 32'sd0, p11: Q_ONE};

   typedef struct packed {
      logic               start;
      logic signed [55:0] num;
      logic signed [40:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         axis;
      logic signed [24:0] angle;
      logic signed [27:0] rate;
   } res_type;

   typedef enum logic [3:0] {
      OP_PRED_ANG   = 4'd0,
      OP_NOISE_ANG  = 4'd1,
      OP_PRED_P00   = 4'd2,
      OP_PRED_CROSS = 4'd3,
      OP_PRED_P11   = 4'd4,
      OP_CORR_P10   = 4'd5,
      OP_CORR_P11   = 4'd6,
      OP_CORR_P01   = 4'd7,
      OP_CORR_P00   = 4'd8,
      OP_CORR_BIAS  = 4'd9,
      OP_CORR_ANG   = 4'd10
   } op_type;

   // round to nearest, halves away from zero
   function automatic logic signed [66:0] rnd_shift(input logic signed [65:0] v,
                                                     input logic [5:0] sh);
      logic signed [66:0] ext;
      logic signed [66:0] half;
      logic signed [66:0] corr;
      logic signed [66:0] t;
      ext  = 67'(v);
      half = 67'sd1 <<< (sh - 6'd1);
      corr = v[65] ? 67'sd1 : 67'sd0;
      t    = ext + half - corr;
      return t >>> sh;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/tak_state_mem.sv
module tak_state_mem #(
   parameter int DEPTH = 3,
   parameter int AW    = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  tak_pkg::state_type   wr_data,
   output tak_pkg::state_type   rd_data
);
   import tak_pkg::*;

   state_type            mem_ff [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   state_type            rd_q_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as the reset state
   assign rd_data = rd_valid_ff ? rd_q_ff : STATE_RESET;

endmodule

### rtl/tak_divider.sv
module tak_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  tak_pkg::div_req_type  req,
   output tak_pkg::div_rsp_type  rsp
);
   import tak_pkg::*;

   logic [55:0]        num_mag;
   logic [40:0]        den_mag;
   logic               ovf;
   logic               busy_ff;
   logic [4:0]         cnt_ff;
   logic [40:0]        rem_ff;
   logic [31:0]        low_ff;
   logic [31:0]        quo_ff;
   logic [40:0]        den_ff;
   logic               neg_ff;
   logic               done_ff;
   logic signed [31:0] result_ff;
   logic [40:0]        trial;
   logic               qbit;
   logic [40:0]        rem_in;
   logic [31:0]        quo_in;
   logic signed [31:0] final_q;

   assign num_mag = req.num[55] ? (~req.num + 56'd1) : req.num;
   assign den_mag = req.den[40] ? (~req.den + 41'd1) : req.den;
   assign ovf     = {17'd0, num_mag[55:32]} >= den_mag;

   assign trial  = {rem_ff[39:0], low_ff[31]};
   assign qbit   = trial >= den_ff;
   assign rem_in = qbit ? (trial - den_ff) : trial;
   assign quo_in = {quo_ff[30:0], qbit};

   always_comb begin
      if (neg_ff) begin
         final_q = (quo_in > 32'h80000000) ? 32'sh80000000 : $signed(32'd0 - quo_in);
      end else begin
         final_q = quo_in[31] ? 32'sh7FFFFFFF : $signed(quo_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            if (den_mag == 41'd0) begin
               result_ff <= 32'sd0;
               done_ff   <= 1'b1;
            end else if (ovf) begin
               result_ff <= (req.num[55] ^ req.den[40]) ? 32'sh80000000 : 32'sh7FFFFFFF;
               done_ff   <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= 5'd0;
               rem_ff  <= {17'd0, num_mag[55:32]};
               low_ff  <= num_mag[31:0];
               quo_ff  <= 32'd0;
               den_ff  <= den_mag;
               neg_ff  <= req.num[55] ^ req.den[40];
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            low_ff <= {low_ff[30:0], 1'b0};
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff   <= 1'b0;
               done_ff   <= 1'b1;
               result_ff <= final_q;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = result_ff;

endmodule

### rtl/tak_engine.sv
module tak_engine #(
   parameter int NUM_AXES = 3,
   parameter int AW       = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             in_axis,
   input  logic signed [24:0]     in_accel,
   input  logic signed [27:0]     in_gyro,
   input  tak_pkg::cfg_type       cfg,
   input  logic                   slot_free,
   output logic                   idle,
   output tak_pkg::res_type       res,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output tak_pkg::state_type     wr_data,
   input  tak_pkg::state_type     rd_data,
   output tak_pkg::div_req_type   div_req,
   input  tak_pkg::div_rsp_type   div_rsp
);
   import tak_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOAD = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_ACC  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_DIVW = 7'b0100000,
      ST_DONE = 7'b1000000
   } st_type;

   st_type             st_ff, st_in;
   op_type             op_ff;
   logic               sel_ff;
   logic [1:0]         axis_ff;
   logic signed [24:0] accel_ff;
   logic signed [27:0] gyro_ff;
   logic signed [31:0] ang_ff, bia_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [39:0] acc_ff;
   logic signed [31:0] k0_ff, k1_ff;
   logic signed [65:0] prod_ff;

   logic               axis_ok;
   logic signed [32:0] mul_a, mul_b;
   logic signed [32:0] dt_s;
   logic signed [31:0] err;
   logic [5:0]         sh;
   logic signed [66:0] r;
   logic signed [67:0] base;
   logic               neg;
   logic signed [31:0] upd, upd2;
   logic signed [39:0] acc_in;
   logic signed [32:0] rate_raw;
   logic signed [40:0] e_val;

   assign axis_ok = {3'b0, in_axis} < 5'(NUM_AXES);
   assign idle    = st_ff == ST_IDLE;
   assign dt_s    = $signed({9'd0, cfg.sample_period});
   assign err     = sat32(68'(accel_ff) - 68'(ang_ff));

   always_comb begin
      mul_a = 33'(p00_ff);
      mul_b = dt_s;
      case (op_ff)
         OP_PRED_ANG:   mul_a = 33'(gyro_ff) - 33'(bia_ff);
         OP_NOISE_ANG:  mul_a = $signed({9'd0, cfg.angle_noise});
         OP_PRED_P00:   mul_a = 33'(p01_ff) + 33'(p10_ff);
         OP_PRED_CROSS: mul_a = 33'(p11_ff);
         OP_PRED_P11:   mul_a = $signed({9'd0, cfg.bias_noise});
         OP_CORR_P10:   begin mul_a = 33'(k1_ff); mul_b = 33'(p00_ff); end
         OP_CORR_P11:   begin mul_a = 33'(k1_ff); mul_b = 33'(p01_ff); end
         OP_CORR_P01:   begin mul_a = 33'(k0_ff); mul_b = 33'(p01_ff); end
         OP_CORR_P00:   begin mul_a = 33'(k0_ff); mul_b = 33'(p00_ff); end
         OP_CORR_BIAS:  begin mul_a = 33'(k1_ff); mul_b = 33'(err); end
         OP_CORR_ANG:   begin mul_a = 33'(k0_ff); mul_b = 33'(err); end
         default:       mul_a = 33'(p00_ff);
      endcase
   end

   always_comb begin
      base = 68'(ang_ff);
      neg  = 1'b0;
      sh   = 6'd16;
      case (op_ff)
         OP_PRED_ANG:   sh = 6'd24;
         OP_NOISE_ANG:  begin base = 68'(p00_ff); sh = 6'd32; end
         OP_PRED_P00:   begin base = 68'(acc_ff); neg = 1'b1; sh = 6'd24; end
         OP_PRED_CROSS: begin base = 68'(p01_ff); neg = 1'b1; sh = 6'd24; end
         OP_PRED_P11:   begin base = 68'(p11_ff); sh = 6'd32; end
         OP_CORR_P10:   begin base = 68'(p10_ff); neg = 1'b1; end
         OP_CORR_P11:   begin base = 68'(p11_ff); neg = 1'b1; end
         OP_CORR_P01:   begin base = 68'(p01_ff); neg = 1'b1; end
         OP_CORR_P00:   begin base = 68'(p00_ff); neg = 1'b1; end
         OP_CORR_BIAS:  base = 68'(bia_ff);
         OP_CORR_ANG:   base = 68'(ang_ff);
         default:       base = 68'(ang_ff);
      endcase
   end

   assign r      = rnd_shift(prod_ff, sh);
   assign upd    = sat32(neg ? (base - 68'(r)) : (base + 68'(r)));
   assign upd2   = sat32(68'(p10_ff) - 68'(r));
   assign acc_in = 40'(base + 68'(r));

   assign e_val = $signed({17'd0, cfg.measure_noise}) + (41'(p00_ff) <<< 8);

   assign div_req.start = st_ff == ST_DIV;
   assign div_req.num   = sel_ff ? $signed({p10_ff, 24'd0}) : $signed({p00_ff, 24'd0});
   assign div_req.den   = e_val;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (start && axis_ok) st_in = ST_LOAD;
         ST_LOAD: st_in = ST_MUL;
         ST_MUL:  st_in = ST_ACC;
         ST_ACC: begin
            if (op_ff == OP_PRED_P11) begin
               st_in = ST_DIV;
            end else if (op_ff == OP_CORR_ANG) begin
               st_in = ST_DONE;
            end else begin
               st_in = ST_MUL;
            end
         end
         ST_DIV:  st_in = ST_DIVW;
         ST_DIVW: if (div_rsp.done) st_in = sel_ff ? ST_MUL : ST_DIV;
         ST_DONE: if (slot_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            axis_ff  <= in_axis;
            accel_ff <= in_accel;
            gyro_ff  <= in_gyro;
         end
         ST_LOAD: begin
            ang_ff <= rd_data.ang;
            bia_ff <= rd_data.bia;
            p00_ff <= rd_data.p00;
            p01_ff <= rd_data.p01;
            p10_ff <= rd_data.p10;
            p11_ff <= rd_data.p11;
            op_ff  <= OP_PRED_ANG;
            sel_ff <= 1'b0;
         end
         ST_MUL: prod_ff <= mul_a * mul_b;
         ST_ACC: begin
            case (op_ff)
               OP_PRED_ANG:   ang_ff <= upd;
               OP_NOISE_ANG:  acc_ff <= acc_in;
               OP_PRED_P00:   p00_ff <= upd;
               OP_PRED_CROSS: begin p01_ff <= upd; p10_ff <= upd2; end
               OP_PRED_P11:   p11_ff <= upd;
               OP_CORR_P10:   p10_ff <= upd;
               OP_CORR_P11:   p11_ff <= upd;
               OP_CORR_P01:   p01_ff <= upd;
               OP_CORR_P00:   p00_ff <= upd;
               OP_CORR_BIAS:  bia_ff <= upd;
               OP_CORR_ANG:   ang_ff <= upd;
               default:       ang_ff <= ang_ff;
            endcase
            if (op_ff != OP_PRED_P11 && op_ff != OP_CORR_ANG) begin
               op_ff <= op_type'(op_ff + 4'd1);
            end
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               if (sel_ff) begin
                  k1_ff <= div_rsp.quot;
                  op_ff <= OP_CORR_P10;
               end else begin
                  k0_ff  <= div_rsp.quot;
                  sel_ff <= 1'b1;
               end
            end
         end
         default: prod_ff <= prod_ff;
      endcase
   end

   assign rd_en   = idle && start && axis_ok;
   assign rd_addr = AW'(in_axis);
   assign wr_en   = (st_ff == ST_DONE) && slot_free;
   assign wr_addr = AW'(axis_ff);
   assign wr_data = '{ang: ang_ff, bia: bia_ff, p00: p00_ff,
                      p01: p01_ff, p10: p10_ff, p11: p11_ff};

   assign rate_raw = 33'(gyro_ff) - 33'(bia_ff);

   always_comb begin
      res.valid = wr_en;
      res.axis  = axis_ff;
      if (33'(ang_ff) > ANGLE_LIMIT) begin
         res.angle = 25'(ANGLE_LIMIT);
      end else if (33'(ang_ff) < -ANGLE_LIMIT) begin
         res.angle = 25'(-ANGLE_LIMIT);
      end else begin
         res.angle = ang_ff[24:0];
      end
      if (rate_raw > RATE_LIMIT) begin
         res.rate = 28'(RATE_LIMIT);
      end else if (rate_raw < -RATE_LIMIT) begin
         res.rate = 28'(-RATE_LIMIT);
      end else begin
         res.rate = rate_raw[27:0];
      end
   end

endmodule

### rtl/tilt_angle_kalman_fusion.sv
// Tilt fusion: one angle/gyro-bias Kalman filter per axis.
// req channel: tuser carries the axis, tdata the accelerometer angle and the
// gyro rate (signed Q9.16 and Q12.16). rsp channel returns the axis, the fused
// angle and the bias-corrected rate, both saturated. csr channel writes the
// Q0.24 noise terms and the sample period; it is always ready, unknown indexes
// are dropped. An item goes from transfer to rsp_tvalid through one load step,
// eleven passes through the shared 33x33 multiplier and two gain divisions on
// the serial 32-step divider. A division whose answer is known at once (zero
// variance or overflow) skips the serial steps, so the item ends sooner. The
// next item can be taken in the cycle after the result leaves the engine.
// The filter state for each axis lives in one memory, read when the item is
// taken and written back when the result leaves.
// One item is in work at a time; req_tready is high while the engine is free,
// also while a finished result still sits in the rsp register. An item whose
// axis has no filter is taken and dropped without a result.
// Reset restores the register defaults and marks every axis as fresh (angle and
// bias zero, unit covariance). A stalled rsp_tready holds the result and holds
// the engine at its last step until the register frees.
module tilt_angle_kalman_fusion #(
   parameter int NUM_AXES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // accel_angle[24:0], gyro_rate[52:25], zero pad
   input  logic [1:0]  req_tuser,   // axis
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // fused_angle[24:0], corrected_rate[52:25], zero pad
   output logic [1:0]  rsp_tuser,   // axis_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);
   import tak_pkg::*;
   `include "tilt_angle_kalman_fusion_assert.svh"

   localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   cfg_type      cfg_ff;
   logic         rsp_tvalid_ff;
   logic [55:0]  rsp_tdata_ff;
   logic [1:0]   rsp_tuser_ff;
   logic         eng_idle;
   logic         slot_free;
   logic         req_xfer;
   res_type      eng_res;
   logic         rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   state_type    wr_data, rd_data;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   assign csr_ready  = 1'b1;
   assign req_tready = eng_idle;
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_noise   <= ANGLE_NOISE_RST;
         cfg_ff.bias_noise    <= BIAS_NOISE_RST;
         cfg_ff.measure_noise <= MEASURE_NOISE_RST;
         cfg_ff.sample_period <= SAMPLE_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANGLE_NOISE:   cfg_ff.angle_noise   <= csr_data[23:0];
            CSR_BIAS_NOISE:    cfg_ff.bias_noise    <= csr_data[23:0];
            CSR_MEASURE_NOISE: cfg_ff.measure_noise <= csr_data[23:0];
            CSR_SAMPLE_PERIOD: cfg_ff.sample_period <= csr_data[23:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (eng_res.valid) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res.valid) begin
         rsp_tdata_ff <= {3'd0, eng_res.rate, eng_res.angle};
         rsp_tuser_ff <= eng_res.axis;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   tak_state_mem #(.DEPTH(NUM_AXES), .AW(AW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   tak_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tak_engine #(.NUM_AXES(NUM_AXES), .AW(AW)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer),
      .in_axis   (req_tuser),
      .in_accel  (req_tdata[24:0]),
      .in_gyro   (req_tdata[52:25]),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .idle      (eng_idle),
      .res       (eng_res),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   `TAK_ASSERT(a_res_into_free_slot, clock, reset, eng_res.valid, slot_free)
   `TAK_ASSERT_NEXT(a_busy_after_take, clock, reset, rd_en, !req_tready)
   `TAK_ASSERT_NEXT(a_no_phantom_rsp, clock, reset, !rsp_tvalid_ff && !eng_res.valid,
                    !rsp_tvalid_ff)
   `TAK_ASSERT(a_write_with_result, clock, reset, wr_en, eng_res.valid)

endmodule
